/* rtl/core/modular_exponentiation_assert.svh */
// Assertion macros shared by the modular exponentiation RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define MODEXP_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset.
`define MODEXP_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* rtl/core/modexp_pkg.sv */
// Types and constants for the modular exponentiation block.
// No dependencies.
`timescale 1ns / 1ps

package modexp_pkg;

    localparam int OPERAND_WIDTH = 62;
    localparam int EXP_WIDTH     = 63;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] t_opnd;
    typedef logic [EXP_WIDTH-1:0]     t_exp;
    typedef logic [CNT_WIDTH-1:0]     t_cnt;

    localparam t_opnd OPND_ZERO = '0;
    localparam t_opnd OPND_ONE  = t_opnd'(1);
    localparam t_cnt  CNT_LAST  = t_cnt'(OPERAND_WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_BIT,
        ST_MUL_DBL,
        ST_MUL_ADD,
        ST_MUL_END,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_opnd base_value;
        t_exp  exponent;
        t_opnd modulus;
    } t_req;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

endpackage

/* rtl/core/modexp_addmod.sv */
// Shared modular adder: (a + b + cin) mod m, valid for a + b + cin < 2m.
// Depends on modexp_pkg.
`timescale 1ns / 1ps

module modexp_addmod import modexp_pkg::*; (
    input  t_opnd i_a,
    input  t_opnd i_b,
    input  logic  i_cin,
    input  t_opnd i_m,
    output t_opnd o_sum
);

    logic [OPERAND_WIDTH:0] sum_raw;
    logic [OPERAND_WIDTH:0] sum_sub;

    assign sum_raw = {1'b0, i_a} + {1'b0, i_b} + {{OPERAND_WIDTH{1'b0}}, i_cin};
    assign sum_sub = sum_raw - {1'b0, i_m};
    assign o_sum   = (sum_raw >= {1'b0, i_m}) ? sum_sub[OPERAND_WIDTH-1:0]
                                              : sum_raw[OPERAND_WIDTH-1:0];

endmodule

/* rtl/core/modexp_core.sv */
// Square-and-multiply sequencer with shift-and-add modular products.
// Depends on modexp_pkg, modexp_addmod and modular_exponentiation_assert.svh.
`timescale 1ns / 1ps
`include "modular_exponentiation_assert.svh"

module modexp_core import modexp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_req       i_req,
    input  logic       i_res_ready,
    output t_core_stat o_stat,
    output t_opnd      o_result
);

    t_state r_state, n_state;
    t_opnd  r_m, n_m;
    t_exp   r_exp, n_exp;
    t_opnd  r_pow, n_pow;
    t_opnd  r_acc, n_acc;
    t_opnd  r_prod, n_prod;
    t_opnd  r_mcand, n_mcand;
    t_opnd  r_mplier, n_mplier;
    t_cnt   r_cnt, n_cnt;
    logic   r_is_sq, n_is_sq;

    t_opnd  add_b;
    logic   add_cin;
    t_opnd  add_sum;
    logic   cnt_last;
    logic   exp_rest_zero;
    t_opnd  mplier_shl;
    t_cnt   cnt_dec;

    assign cnt_last      = (r_cnt == '0);
    assign exp_rest_zero = (r_exp[EXP_WIDTH-1:1] == '0);
    assign mplier_shl    = {r_mplier[OPERAND_WIDTH-2:0], 1'b0};
    assign cnt_dec       = r_cnt - t_cnt'(1);

    assign add_b   = (r_state == ST_MUL_ADD) ? r_mcand : r_prod;
    assign add_cin = (r_state == ST_REDUCE) ? r_mplier[OPERAND_WIDTH-1] : 1'b0;

    modexp_addmod u_addmod (
        .i_a   (r_prod),
        .i_b   (add_b),
        .i_cin (add_cin),
        .i_m   (r_m),
        .o_sum (add_sum)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_req.exponent == '0 || i_req.modulus == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (cnt_last) begin
                    n_state = ST_BIT;
                end
            end
            ST_BIT: begin
                n_state = ST_MUL_DBL;
            end
            ST_MUL_DBL: begin
                if (r_mplier[OPERAND_WIDTH-1]) begin
                    n_state = ST_MUL_ADD;
                end else if (cnt_last) begin
                    n_state = ST_MUL_END;
                end
            end
            ST_MUL_ADD: begin
                n_state = cnt_last ? ST_MUL_END : ST_MUL_DBL;
            end
            ST_MUL_END: begin
                if (r_is_sq) begin
                    n_state = ST_BIT;
                end else if (exp_rest_zero) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL_DBL;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m      = r_m;
        n_exp    = r_exp;
        n_pow    = r_pow;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_is_sq  = r_is_sq;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_m      = i_req.modulus;
                    n_exp    = i_req.exponent;
                    n_mplier = i_req.base_value;
                    n_prod   = OPND_ZERO;
                    n_cnt    = CNT_LAST;
                    n_acc    = (i_req.exponent == '0) ? OPND_ONE : OPND_ZERO;
                end
            end
            ST_REDUCE: begin
                n_prod   = add_sum;
                n_mplier = mplier_shl;
                n_cnt    = cnt_dec;
                if (cnt_last) begin
                    n_pow = add_sum;
                    n_acc = (r_m == OPND_ONE) ? OPND_ZERO : OPND_ONE;
                end
            end
            ST_BIT: begin
                n_prod  = OPND_ZERO;
                n_cnt   = CNT_LAST;
                n_mcand = r_pow;
                if (r_exp[0]) begin
                    n_mplier = r_acc;
                    n_is_sq  = 1'b0;
                end else begin
                    n_mplier = r_pow;
                    n_is_sq  = 1'b1;
                end
            end
            ST_MUL_DBL: begin
                n_prod = add_sum;
                if (!r_mplier[OPERAND_WIDTH-1]) begin
                    n_mplier = mplier_shl;
                    if (!cnt_last) begin
                        n_cnt = cnt_dec;
                    end
                end
            end
            ST_MUL_ADD: begin
                n_prod   = add_sum;
                n_mplier = mplier_shl;
                if (!cnt_last) begin
                    n_cnt = cnt_dec;
                end
            end
            ST_MUL_END: begin
                if (r_is_sq) begin
                    n_pow = r_prod;
                    n_exp = r_exp >> 1;
                end else begin
                    // multiply done; square of the same power follows unless no higher bit is set
                    n_acc    = r_prod;
                    n_mplier = r_pow;
                    n_mcand  = r_pow;
                    n_prod   = OPND_ZERO;
                    n_cnt    = CNT_LAST;
                    n_is_sq  = 1'b1;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m      <= n_m;
        r_exp    <= n_exp;
        r_pow    <= n_pow;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
        r_is_sq  <= n_is_sq;
    end

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_result    = r_acc;

    `MODEXP_ASSERT(a_prod_reduced, i_clk, i_rst_n, ((r_state == ST_MUL_DBL || r_state == ST_MUL_ADD) |-> (r_prod < r_m)), "partial product not reduced")
    `MODEXP_ASSERT(a_mcand_reduced, i_clk, i_rst_n, ((r_state == ST_MUL_ADD) |-> (r_mcand < r_m)), "multiplicand not reduced")
    `MODEXP_NEVER(a_start_busy, i_clk, i_rst_n, (i_start && r_state != ST_IDLE), "start while busy")
    `MODEXP_ASSERT(a_done_holds, i_clk, i_rst_n, ((r_state == ST_DONE && !i_res_ready) |=> (r_state == ST_DONE)), "result dropped")

endmodule

/* rtl/core/modular_exponentiation.sv */
// Top level of the modular exponentiation block: request/result handshake and
// output register around the sequencer. Depends on modexp_pkg and modexp_core.
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_ready    i_base_value, i_exponent, i_modulus
//   result    out        o_out_valid / i_out_ready  o_power_result
//
// One request at a time; o_in_ready is high only while the sequencer is idle.
// The base is first reduced mod the modulus, one step per base bit; each exponent
// bit up to the top set bit gets a decision step, then, if set, a multiply, then
// a square (except after the top bit); a product doubles once per multiplier bit
// and adds the multiplicand for each set bit on the single shared modular adder.
// A zero exponent or zero modulus goes from idle straight to the done state.
// A result held in the output register does not block the next request.
// Reset (synchronous, active low) clears the sequencer state and o_out_valid.
`timescale 1ns / 1ps

module modular_exponentiation import modexp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_opnd i_base_value,
    input  t_exp  i_exponent,
    input  t_opnd i_modulus,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_opnd o_power_result
);

    t_req       req;
    t_core_stat core_stat;
    t_opnd      core_result;
    logic       res_ready;
    logic       start;
    logic       r_out_valid, n_out_valid;
    t_opnd      r_result, n_result;

    assign req.base_value = i_base_value;
    assign req.exponent   = i_exponent;
    assign req.modulus    = i_modulus;

    assign o_in_ready = core_stat.idle;
    assign start      = i_in_valid && core_stat.idle;
    assign res_ready  = !r_out_valid || i_out_ready;

    modexp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_res_ready (res_ready),
        .o_stat      (core_stat),
        .o_result    (core_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_result    = r_result;
        if (core_stat.done && res_ready) begin
            n_out_valid = 1'b1;
            n_result    = core_result;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_result;

endmodule
